>>> hdl/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int PAGE_BITS   = 16;
  localparam int CFG_W       = 4;
  localparam int COUNT_W     = 32;
  localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CFG_RESET   = 8;

  typedef logic [PAGE_BITS-1:0] page_t;

  // one frame of the recency chain
  typedef struct packed {
    logic  valid;
    page_t page;
  } lpr_entry_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic step;
    logic clear;
    logic hit_any;
  } lpr_ctl_t;

  localparam lpr_entry_t EMPTY_ENTRY = '{valid: 1'b0, page: '0};

endpackage

>>> hdl/lru_page_replacement.sv
`timescale 1ns / 1ps
// LRU page replacement over up to MAX_FRAMES frames.
// Input channel: page_i with in_valid_i / in_stall_o; a word is taken at a
// clock edge with in_valid_i high and in_stall_o low. Each word is one page
// reference.
// Output channel: fault_o, victim_valid_o, victim_page_o, fault_total_o with
// out_valid_o / out_stall_i; one result word per reference.
// The result is registered and shown in the cycle after the reference is
// taken. Throughput is one reference per cycle while the receiver does not
// stall, set by the compare-and-shift along the chain of frame cells.
// When the receiver stalls, the result word holds and in_stall_o rises, so
// at most one result is ever waiting. frames_in_use_i is written when
// cfg_we_i is high; the user must do so only while the block is idle, and
// the block does not enforce it. Each write empties every frame and keeps
// the fault count. Reset empties all frames, clears the fault count and
// sets the frame count to eight. Zero acts as one, above MAX_FRAMES as max.
module lru_page_replacement (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpr_pkg::CFG_W-1:0]     frames_in_use_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lpr_pkg::PAGE_BITS-1:0] page_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          fault_o,
  output logic                          victim_valid_o,
  output logic [lpr_pkg::PAGE_BITS-1:0] victim_page_o,
  output logic [lpr_pkg::COUNT_W-1:0]   fault_total_o
);

  logic [lpr_pkg::CFG_W-1:0]       frames_q;
  logic [lpr_pkg::FRAME_CNT_W-1:0] n_act;
  logic [lpr_pkg::COUNT_W-1:0]     cnt_q, cnt_d;
  logic                            out_valid_q;
  logic                            fault_q, vv_q;
  lpr_pkg::page_t                  vp_q;
  logic                            accept;
  lpr_pkg::lpr_ctl_t               ctl;

  lpr_pkg::lpr_entry_t entries [lpr_pkg::MAX_FRAMES];
  logic [lpr_pkg::MAX_FRAMES:0] seen;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    if (frames_q == '0) begin
      n_act = lpr_pkg::FRAME_CNT_W'(1);
    end else if (32'(frames_q) > 32'(lpr_pkg::MAX_FRAMES)) begin
      n_act = lpr_pkg::FRAME_CNT_W'(lpr_pkg::MAX_FRAMES);
    end else begin
      n_act = lpr_pkg::FRAME_CNT_W'(frames_q);
    end
  end

  assign seen[0]     = 1'b0;
  assign ctl.step    = accept;
  assign ctl.clear   = cfg_we_i;
  assign ctl.hit_any = seen[lpr_pkg::MAX_FRAMES];

  for (genvar i = 0; i < lpr_pkg::MAX_FRAMES; i++) begin : g_cell
    lpr_pkg::lpr_entry_t upper;
    if (i == lpr_pkg::MAX_FRAMES - 1) begin : g_last
      assign upper = lpr_pkg::EMPTY_ENTRY;
    end else begin : g_mid
      assign upper = entries[i+1];
    end
    lpr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .active_i   (lpr_pkg::FRAME_CNT_W'(i) < n_act),
      .is_top_i   (lpr_pkg::FRAME_CNT_W'(i + 1) == n_act),
      .ref_page_i (page_i),
      .upper_i    (upper),
      .seen_i     (seen[i]),
      .entry_o    (entries[i]),
      .seen_o     (seen[i+1])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !ctl.hit_any && (cnt_q != '1)) begin
      cnt_d = cnt_q + lpr_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= lpr_pkg::CFG_W'(lpr_pkg::CFG_RESET);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frames_q <= frames_in_use_i;
      end
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // victim is always the least recent frame
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fault_q <= ~ctl.hit_any;
      vv_q    <= ~ctl.hit_any & entries[0].valid;
      vp_q    <= (~ctl.hit_any & entries[0].valid) ? entries[0].page : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fault_o        = fault_q;
  assign victim_valid_o = vv_q;
  assign victim_page_o  = vp_q;
  assign fault_total_o  = cnt_q;

endmodule

>>> hdl/lpr_cell.sv
`timescale 1ns / 1ps

module lpr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpr_pkg::lpr_ctl_t   ctl_i,
  input  logic                active_i,
  input  logic                is_top_i,
  input  lpr_pkg::page_t      ref_page_i,
  input  lpr_pkg::lpr_entry_t upper_i,
  input  logic                seen_i,
  output lpr_pkg::lpr_entry_t entry_o,
  output logic                seen_o
);

  logic           valid_q, valid_d;
  lpr_pkg::page_t page_q, page_d;
  logic           match;
  logic           shift;

  assign match  = active_i & valid_q & (page_q == ref_page_i);
  // hit at or below this position, handed on to the next cell up
  assign seen_o = seen_i | match;
  // on a miss the whole active chain moves down by one
  assign shift  = active_i & (~ctl_i.hit_any | seen_o);

  always_comb begin
    valid_d = valid_q;
    page_d  = page_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.step && shift) begin
      if (is_top_i) begin
        valid_d = 1'b1;
        page_d  = ref_page_i;
      end else begin
        valid_d = upper_i.valid;
        page_d  = upper_i.page;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign entry_o = '{valid: valid_q, page: page_q};

endmodule

>>> hdl/lpr_checker.sv
`timescale 1ns / 1ps

module lpr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [lpr_pkg::CFG_W-1:0]     frames_in_use_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [lpr_pkg::PAGE_BITS-1:0] page_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          fault_o,
  input logic                          victim_valid_o,
  input logic [lpr_pkg::PAGE_BITS-1:0] victim_page_o,
  input logic [lpr_pkg::COUNT_W-1:0]   fault_total_o
);

  // a hit never evicts
  a_hit_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !fault_o) |-> !victim_valid_o)
    else $error("victim reported on a hit");

  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !victim_valid_o) |-> (victim_page_o == '0))
    else $error("victim page not zero without a victim");

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted reference gave no result");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with output free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(fault_o) && $stable(victim_valid_o) &&
       $stable(victim_page_o) && $stable(fault_total_o)))
    else $error("stalled result word changed");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);
